// ===== rtl/mmbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmbc_pkg
// shared types and constants of the min/max box color classifier
// ----------------------------------------------------------------------------
package mmbc_pkg;

    typedef logic [1:0] cmd_t;
    typedef logic [1:0] class_code_t;

    // command codes of an input word
    localparam cmd_t CMD_SAMPLE = 2'd0;
    localparam cmd_t CMD_START  = 2'd1;
    localparam cmd_t CMD_TICK   = 2'd2;

    // reported class codes
    localparam class_code_t DETECT_NONE = 2'd0;

    // fixed port widths
    localparam int WIDTH_BITS    = 20;
    localparam int DURATION_BITS = 16;

    // three color channels per box, only red, green, blue have a code
    localparam int NUM_CHANNELS = 3;
    localparam int REPORTABLE   = 3;

    localparam logic [31:0] LOW_RESET = 32'd999999;
    localparam logic [DURATION_BITS-1:0] DURATION_RESET = 16'd5000;
    localparam logic [DURATION_BITS-1:0] TICKS_MAX      = 16'hFFFF;

endpackage
`default_nettype wire

// ===== rtl/min_max_box_color_classifier_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_max_box_color_classifier_top
// classifies rgb pulse-width samples against trained min/max boxes
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries one word: command, class_select
//   and the three pulse widths. command sample classifies the widths, or
//   widens the box under calibration while a window is open; start clears one
//   class's box and opens a window; tick counts a millisecond of the window
//   output channel (out_valid/out_ready) returns exactly one word per input
//   word: detected_class, calibrating, calibration_done
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes calib_duration; always
//   ready, write it only while the block is idle
// timing
//   the boxes live in one memory, one row per class, read one row a cycle
//   start, tick and calibration sample words pass from the payload registers
//   to the output register; a classified sample reads the boxes in turn, one
//   box read per cycle from the single memory read port, up to the first match
//   or the last reportable box; a new word is taken in the cycle the previous
//   one finishes, so non-classify words flow at one per cycle unless the output stalls
//   a stalled result sits in the output register while the next word is
//   taken and worked on; input stalls once that word is done and waiting too
// reset: box rows read untrained (lower 999999, upper 0) through per-row
//   valid bits, no clearing pass; no window open; calib_duration 5000
// ----------------------------------------------------------------------------
module min_max_box_color_classifier_top
    import mmbc_pkg::*;
#(
    parameter int NUM_CLASSES = 3,
    parameter int SAMPLE_BITS = 20
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // input words
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               command,
    input  wire logic [1:0]               class_select,
    input  wire logic [WIDTH_BITS-1:0]    red_width,
    input  wire logic [WIDTH_BITS-1:0]    green_width,
    input  wire logic [WIDTH_BITS-1:0]    blue_width,
    // result words
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [1:0]                    detected_class,
    output logic                          calibrating,
    output logic                          calibration_done,
    // configuration write
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [DURATION_BITS-1:0] cfg_data
);

    localparam int ADDR_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int BOX_W    = 2 * NUM_CHANNELS * SAMPLE_BITS;
    localparam int NREP     = (NUM_CLASSES < REPORTABLE) ? NUM_CLASSES : REPORTABLE;
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NREP - 1);
    localparam logic [SAMPLE_BITS-1:0] LOW_VAL = LOW_RESET[SAMPLE_BITS-1:0];

    // box word: lower bounds in the low half, upper bounds in the high half
    function automatic logic [BOX_W-1:0] reset_box();
        logic [BOX_W-1:0] b;
        b = '0;
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            b[ch*SAMPLE_BITS +: SAMPLE_BITS] = LOW_VAL;
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic                          busy_reg;
    cmd_t                          cmd_reg;
    logic [1:0]                    sel_reg;
    logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] smp_reg;
    logic [ADDR_W-1:0]             cls_idx_reg;

    logic                          calib_active_reg, calib_active_next;
    logic [1:0]                    calib_class_reg, calib_class_next;
    logic [DURATION_BITS-1:0]      elapsed_reg, elapsed_next;
    logic [DURATION_BITS-1:0]      duration_reg;

    logic [NUM_CLASSES-1:0]        row_valid_reg;
    logic                          rd_valid_reg;
    logic                          fwd_reg;
    logic [BOX_W-1:0]              fwd_data_reg;

    logic                          out_valid_reg;
    class_code_t                   detected_reg, detected_next;
    logic                          calibrating_reg;
    logic                          done_reg, done_next;

    // ------------------------------------------------------------------
    // memory and its access control
    // ------------------------------------------------------------------
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [BOX_W-1:0]              ram_wdata;
    logic                          ram_re;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [BOX_W-1:0]              ram_rdata;
    logic                          fwd_hit;

    mmbc_ram #(
        .WIDTH (BOX_W),
        .DEPTH (NUM_CLASSES)
    ) u_box_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // execute: box under test, compare and widen
    // ------------------------------------------------------------------
    logic [BOX_W-1:0] box_cur;
    logic [BOX_W-1:0] box_wide;
    logic             match;
    logic             is_sample;
    logic             is_classify;
    logic             sel_ok;
    logic             out_free;
    logic             finish;
    logic             step;
    logic             accept;

    // untrained rows read as the reset box; a same-cycle write is forwarded
    assign box_cur = !rd_valid_reg ? reset_box() :
                     (fwd_reg ? fwd_data_reg : ram_rdata);

    always_comb
    begin
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] up;
        match    = 1'b1;
        box_wide = box_cur;
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            lo = box_cur[ch*SAMPLE_BITS +: SAMPLE_BITS];
            up = box_cur[(NUM_CHANNELS+ch)*SAMPLE_BITS +: SAMPLE_BITS];
            if (smp_reg[ch] < lo || smp_reg[ch] > up)
            begin
                match = 1'b0;
            end
            if (smp_reg[ch] < lo)
            begin
                box_wide[ch*SAMPLE_BITS +: SAMPLE_BITS] = smp_reg[ch];
            end
            if (smp_reg[ch] > up)
            begin
                box_wide[(NUM_CHANNELS+ch)*SAMPLE_BITS +: SAMPLE_BITS] = smp_reg[ch];
            end
        end
    end

    assign is_sample   = (cmd_reg == CMD_SAMPLE);
    assign is_classify = is_sample && !calib_active_reg;
    assign sel_ok      = (int'(sel_reg) < NUM_CLASSES);
    assign out_free    = !out_valid_reg || out_ready;

    // a classify word walks the boxes until a hit or the last reportable one
    assign finish = busy_reg && out_free &&
                    (!is_classify || match || (cls_idx_reg == LAST_IDX));
    assign step   = busy_reg && is_classify && !match && (cls_idx_reg != LAST_IDX);

    assign in_ready = !busy_reg || finish;
    assign accept   = in_valid && in_ready;

    // ------------------------------------------------------------------
    // state update of the finishing word
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [DURATION_BITS-1:0] ticks;
        calib_active_next = calib_active_reg;
        calib_class_next  = calib_class_reg;
        elapsed_next      = elapsed_reg;
        detected_next     = DETECT_NONE;
        done_next         = 1'b0;
        ticks             = (elapsed_reg < TICKS_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
        if (finish)
        begin
            case (cmd_reg)
                CMD_SAMPLE:
                begin
                    if (!calib_active_reg && match)
                    begin
                        detected_next = 2'(cls_idx_reg) + 2'd1;
                    end
                end
                CMD_START:
                begin
                    if (sel_ok)
                    begin
                        calib_class_next  = sel_reg;
                        calib_active_next = 1'b1;
                        elapsed_next      = '0;
                    end
                end
                CMD_TICK:
                begin
                    if (calib_active_reg)
                    begin
                        elapsed_next = ticks;
                        if (ticks >= duration_reg)
                        begin
                            calib_active_next = 1'b0;
                            done_next         = 1'b1;
                        end
                    end
                end
                default:
                begin
                    calib_active_next = calib_active_reg;
                end
            endcase
        end
    end

    // write back: widened box of a calibration sample, or cleared box on start
    assign ram_we    = finish && ((is_sample && calib_active_reg) ||
                                  (cmd_reg == CMD_START && sel_ok));
    assign ram_waddr = (cmd_reg == CMD_START) ? ADDR_W'(sel_reg) : ADDR_W'(calib_class_reg);
    assign ram_wdata = (cmd_reg == CMD_START) ? reset_box() : box_wide;

    // read: first box of a new word (uses the state this cycle leaves),
    // or the next box of a classify walk
    assign ram_re    = accept || step;
    assign ram_raddr = step ? (cls_idx_reg + 1'b1) :
                       ((command == CMD_SAMPLE && calib_active_next) ?
                        ADDR_W'(calib_class_next) : '0);
    assign fwd_hit   = ram_we && (ram_waddr == ram_raddr);

    // ------------------------------------------------------------------
    // sequential logic
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            cls_idx_reg      <= '0;
            calib_active_reg <= 1'b0;
            calib_class_reg  <= '0;
            elapsed_reg      <= '0;
            duration_reg     <= DURATION_RESET;
            row_valid_reg    <= '0;
            rd_valid_reg     <= 1'b0;
            fwd_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg    <= 1'b1;
                cls_idx_reg <= '0;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
            else if (step)
            begin
                cls_idx_reg <= cls_idx_reg + 1'b1;
            end

            calib_active_reg <= calib_active_next;
            calib_class_reg  <= calib_class_next;
            elapsed_reg      <= elapsed_next;

            if (cfg_valid && cfg_ready)
            begin
                duration_reg <= cfg_data;
            end

            if (ram_we)
            begin
                row_valid_reg[ram_waddr] <= 1'b1;
            end

            if (ram_re)
            begin
                rd_valid_reg <= row_valid_reg[ram_raddr] || fwd_hit;
                fwd_reg      <= fwd_hit;
            end

            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            sel_reg    <= class_select;
            smp_reg[0] <= SAMPLE_BITS'(red_width);
            smp_reg[1] <= SAMPLE_BITS'(green_width);
            smp_reg[2] <= SAMPLE_BITS'(blue_width);
        end
        if (ram_re)
        begin
            fwd_data_reg <= ram_wdata;
        end
        if (finish)
        begin
            detected_reg    <= detected_next;
            calibrating_reg <= calib_active_next;
            done_reg        <= done_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign detected_class   = detected_reg;
    assign calibrating      = calibrating_reg;
    assign calibration_done = done_reg;
    assign cfg_ready        = 1'b1;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a word never finishes while the output register is full and stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !finish)
        else $error("result finished into a stalled output register");

    // the classify walk never reads past the last reportable box
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> (cls_idx_reg != LAST_IDX) && !ram_we)
        else $error("classify walk past last box or with a write");

    // a closing tick leaves the window closed
    a_done_closed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(done_reg && calibrating_reg))
        else $error("calibration done reported with window still open");

    // a valid start restarts the tick count
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && cmd_reg == CMD_START && sel_ok) |=>
        (elapsed_reg == '0) && calib_active_reg)
        else $error("start did not restart the calibration window");

endmodule
`default_nettype wire

// ===== rtl/mmbc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmbc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mmbc_ram #(
    parameter int WIDTH     = 8,
    parameter int DEPTH     = 4,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic                 re,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read holds its data while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire
